@@ rtl/bfge_pkg.sv @@
// ----------------------------------------------------------------------------
// bfge_pkg: battery fuel gauge estimator shared definitions
// Field widths, register indexes, charge state codes and the fixed-point
// constants of the estimate.
// ----------------------------------------------------------------------------
package bfge_pkg;

    // Field widths
    localparam int K_ADC_W     = 8;
    localparam int K_MV_W      = 10;
    localparam int K_VOLT_W    = 16;
    localparam int K_RINT_W    = 10;
    localparam int K_DB_W      = 8;
    localparam int K_LIMIT_W   = 16;
    localparam int K_PCT_W     = 7;
    localparam int K_STATE_W   = 2;
    localparam int K_CUR_W     = 18;
    localparam int K_CFG_IDX_W = 3;
    localparam int K_CFG_DAT_W = 16;

    // Register indexes on the configuration port
    localparam logic [K_CFG_IDX_W-1:0] REG_RINT     = 3'd0;
    localparam logic [K_CFG_IDX_W-1:0] REG_DEADBAND = 3'd1;
    localparam logic [K_CFG_IDX_W-1:0] REG_SEED_MV  = 3'd2;
    localparam logic [K_CFG_IDX_W-1:0] REG_FULL_MV  = 3'd3;
    localparam logic [K_CFG_IDX_W-1:0] REG_CHGD_MV  = 3'd4;
    localparam logic [K_CFG_IDX_W-1:0] REG_DIS_LIM  = 3'd5;
    localparam logic [K_CFG_IDX_W-1:0] REG_CHGD_LIM = 3'd6;

    // Register reset values
    localparam logic [K_RINT_W-1:0]         RST_RINT     = 10'd256;
    localparam logic [K_DB_W-1:0]           RST_DEADBAND = 8'd25;
    localparam logic [K_VOLT_W-1:0]         RST_SEED_MV  = 16'd3800;
    localparam logic [K_VOLT_W-1:0]         RST_FULL_MV  = 16'd4025;
    localparam logic [K_VOLT_W-1:0]         RST_CHGD_MV  = 16'd4050;
    localparam logic signed [K_LIMIT_W-1:0] RST_DIS_LIM  = -16'sd60;
    localparam logic signed [K_LIMIT_W-1:0] RST_CHGD_LIM = -16'sd40;

    // Charge state codes
    typedef enum logic [K_STATE_W-1:0] {
        CS_DISCHARGING = 2'd0,
        CS_CHARGING    = 2'd1,
        CS_CHARGED     = 2'd2
    } t_charge;

    // Estimate constants
    localparam logic [11:0] K_MV_GAIN  = 12'd3000;  // mv = adc * 3000 / 1024
    localparam logic [9:0]  K_DIV_15   = 10'd15;
    localparam logic [9:0]  K_DIV_1000 = 10'd1000;
    localparam logic [18:0] K_PCT_BASE = 19'd1500;
    localparam logic [18:0] K_PCT_SAT  = 19'd1515;  // first numerator giving > 100

    function automatic logic [K_MV_W-1:0] to_mv(input logic [K_ADC_W-1:0] adc);
        logic [19:0] prod;
        prod = {12'b0, adc} * {8'b0, K_MV_GAIN};
        return prod[19:10];
    endfunction

endpackage

@@ rtl/bfge_in_if.sv @@
// ----------------------------------------------------------------------------
// bfge_in_if: sample channel
// Valid/ready channel carrying one pair of ADC samples and the seed flag.
// ----------------------------------------------------------------------------
interface bfge_in_if;
    import bfge_pkg::*;

    logic               valid;
    logic               ready;
    logic [K_ADC_W-1:0] sys_adc;
    logic [K_ADC_W-1:0] bat_adc;
    logic               seed;

    modport source (output valid, sys_adc, bat_adc, seed, input ready);
    modport sink   (input valid, sys_adc, bat_adc, seed, output ready);
endinterface

@@ rtl/bfge_out_if.sv @@
// ----------------------------------------------------------------------------
// bfge_out_if: estimate channel
// Valid/ready channel carrying one fuel gauge estimate.
// ----------------------------------------------------------------------------
interface bfge_out_if;
    import bfge_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [K_PCT_W-1:0]        percent;
    logic [K_STATE_W-1:0]      charge_state;
    logic signed [K_CUR_W-1:0] current_ma;
    logic [K_VOLT_W-1:0]       indicator_mv;
    logic                      changed;

    modport source (output valid, percent, charge_state, current_ma, indicator_mv, changed,
                    input ready);
    modport sink   (input valid, percent, charge_state, current_ma, indicator_mv, changed,
                    output ready);
endinterface

@@ rtl/battery_fuel_gauge_estimator_core.sv @@
// ----------------------------------------------------------------------------
// battery_fuel_gauge_estimator_core: battery fuel gauge estimator
// Filters ADC samples, estimates current and compensated voltage, steps a
// slew-limited indicator and reports percent, charge state and change flag.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    sys_adc, bat_adc, seed
//  o_out    out  valid/ready    percent, charge_state, current_ma, indicator_mv, changed
//  i_cfg    in   i_cfg_we       i_cfg_idx, i_cfg_data
//
// One item at a time. A seed item loads the filters and indicator and goes
// straight to output. An estimate runs a bit-serial divide by 15, a shift-add
// multiply by the internal resistance, a bit-serial divide by 1000, an
// indicator step and, when percent is not clamped, a divide by 15.
// Reset is synchronous and clears state; config returns to its defaults.
// A stalled output holds the finished estimate; the next transfer on i_in is
// taken while it waits, and the sequencer parks before output if it still waits.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_estimator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bfge_pkg::K_CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bfge_pkg::K_CFG_DAT_W-1:0]    i_cfg_data,
    bfge_in_if.sink                             i_in,
    bfge_out_if.source                          o_out
);
    import bfge_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_D,
        S_MUL,
        S_DIV_DROP,
        S_STEP,
        S_PCT,
        S_DIV_PCT,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration
    logic [K_RINT_W-1:0]         r_cfg_rint;
    logic [K_DB_W-1:0]           r_cfg_db;
    logic [K_VOLT_W-1:0]         r_cfg_seed;
    logic [K_VOLT_W-1:0]         r_cfg_full;
    logic [K_VOLT_W-1:0]         r_cfg_chgd;
    logic signed [K_LIMIT_W-1:0] r_cfg_dlim;
    logic signed [K_LIMIT_W-1:0] r_cfg_clim;

    // Estimator state
    logic [K_VOLT_W-1:0]  r_sys_acc;
    logic [K_VOLT_W-1:0]  r_bat_acc;
    logic [K_VOLT_W-1:0]  r_ind;
    logic [K_STATE_W-1:0] r_status;
    logic [K_PCT_W-1:0]   r_prev_pct;

    // Work registers
    logic                      r_seed;
    logic                      r_neg;
    logic [12:0]               r_dmag;
    logic signed [K_CUR_W-1:0] r_cur;
    logic [K_PCT_W-1:0]        r_pct;
    logic [26:0]               r_dq;      // dividend/quotient, also the product
    logic [9:0]                r_rem;
    logic [9:0]                r_divisor;
    logic [26:0]               r_mcand;
    logic [K_RINT_W-1:0]       r_mplier;
    logic [4:0]                r_cnt;

    // Output register
    logic                      r_out_valid;
    logic [K_PCT_W-1:0]        r_out_pct;
    logic [K_STATE_W-1:0]      r_out_state;
    logic signed [K_CUR_W-1:0] r_out_cur;
    logic [K_VOLT_W-1:0]       r_out_ind;
    logic                      r_out_chg;

    // Sample filters
    logic [K_MV_W-1:0]   w_sys_mv;
    logic [K_MV_W-1:0]   w_bat_mv;
    logic [K_VOLT_W-1:0] w_sys_next;
    logic [K_VOLT_W-1:0] w_bat_next;
    logic [16:0]         w_diff;
    logic [16:0]         w_mag;
    logic [15:0]         w_dend;

    always_comb begin
        w_sys_mv   = to_mv(i_in.sys_adc);
        w_bat_mv   = to_mv(i_in.bat_adc);
        w_sys_next = r_sys_acc - (r_sys_acc >> 3) + {6'b0, w_sys_mv};
        w_bat_next = r_bat_acc - (r_bat_acc >> 3) + {6'b0, w_bat_mv};
        w_diff     = {1'b0, w_bat_next} - {1'b0, w_sys_next};
        w_mag      = w_diff[16] ? 17'(-w_diff) : w_diff;
        // truncate toward zero on the magnitude, then scale by 16 for the /15
        w_dend     = {w_mag[15:4], 4'b0};
    end

    // Shared restoring divider step: one quotient bit per cycle
    logic [10:0] w_div_sh;
    logic        w_div_ge;
    logic [9:0]  w_div_rem;
    logic [26:0] w_div_dq;

    always_comb begin
        w_div_sh  = {r_rem, r_dq[26]};
        w_div_ge  = w_div_sh >= {1'b0, r_divisor};
        w_div_rem = w_div_ge ? 10'(w_div_sh - {1'b0, r_divisor}) : w_div_sh[9:0];
        w_div_dq  = {r_dq[25:0], w_div_ge};
    end

    // Shift-add multiply step
    logic [26:0] w_mul_sum;
    assign w_mul_sum = r_dq + (r_mplier[0] ? r_mcand : 27'd0);

    // Current from the corrected difference
    logic [16:0]               w_cur_mag;
    logic signed [K_CUR_W-1:0] w_cur;
    always_comb begin
        w_cur_mag = {w_div_dq[12:0], 4'b0} + {2'b0, w_div_dq[12:0], 2'b0};
        w_cur     = r_neg ? -$signed({1'b0, w_cur_mag}) : $signed({1'b0, w_cur_mag});
    end

    // Compensated voltage and indicator step
    logic [K_VOLT_W-1:0] w_dmag16;
    logic [K_VOLT_W-1:0] w_comp;
    logic [16:0]         w_hi;
    logic [16:0]         w_lo;
    logic [K_VOLT_W-1:0] w_ind_next;

    always_comb begin
        w_dmag16 = {3'b0, r_dmag};
        // drop has the sign of the current, which has the sign of d
        w_comp   = r_neg ? (r_sys_acc + w_dmag16 + r_dq[15:0])
                         : (r_sys_acc - w_dmag16 - r_dq[15:0]);
        w_hi     = {1'b0, r_ind} + {9'b0, r_cfg_db};
        w_lo     = {1'b0, w_comp} + {9'b0, r_cfg_db};
        if ({1'b0, w_comp} > w_hi) begin
            w_ind_next = r_ind + 16'd1;
        end else if (w_lo < {1'b0, r_ind}) begin
            w_ind_next = r_ind - 16'd1;
        end else begin
            w_ind_next = r_ind;
        end
    end

    // Percent numerator: 1500 - 2 * (full - ind)
    logic [18:0] w_num;
    assign w_num = K_PCT_BASE + {2'b0, r_ind, 1'b0} - {2'b0, r_cfg_full, 1'b0};

    // Charge state update
    logic [K_STATE_W-1:0] w_status;
    logic                 w_changed;
    always_comb begin
        w_status = r_status;
        if (r_cur < K_CUR_W'(r_cfg_dlim)) begin
            w_status = CS_DISCHARGING;
        end
        if (r_cur >= 0) begin
            w_status = CS_CHARGING;
        end
        if (r_ind > r_cfg_chgd && r_cur > K_CUR_W'(r_cfg_clim)) begin
            w_status = CS_CHARGED;
        end
        w_changed = (w_status != r_status) || (r_pct != r_prev_pct);
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.percent      = r_out_pct;
    assign o_out.charge_state = r_out_state;
    assign o_out.current_ma   = r_out_cur;
    assign o_out.indicator_mv = r_out_ind;
    assign o_out.changed      = r_out_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_rint  <= RST_RINT;
            r_cfg_db    <= RST_DEADBAND;
            r_cfg_seed  <= RST_SEED_MV;
            r_cfg_full  <= RST_FULL_MV;
            r_cfg_chgd  <= RST_CHGD_MV;
            r_cfg_dlim  <= RST_DIS_LIM;
            r_cfg_clim  <= RST_CHGD_LIM;
            r_sys_acc   <= '0;
            r_bat_acc   <= '0;
            r_ind       <= '0;
            r_status    <= CS_DISCHARGING;
            r_prev_pct  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RINT:     r_cfg_rint <= i_cfg_data[K_RINT_W-1:0];
                    REG_DEADBAND: r_cfg_db   <= i_cfg_data[K_DB_W-1:0];
                    REG_SEED_MV:  r_cfg_seed <= i_cfg_data;
                    REG_FULL_MV:  r_cfg_full <= i_cfg_data;
                    REG_CHGD_MV:  r_cfg_chgd <= i_cfg_data;
                    REG_DIS_LIM:  r_cfg_dlim <= $signed(i_cfg_data);
                    REG_CHGD_LIM: r_cfg_clim <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_seed <= i_in.seed;
                        if (i_in.seed) begin
                            r_sys_acc <= {4'b0, i_in.sys_adc, 4'b0};
                            r_bat_acc <= {4'b0, i_in.sys_adc, 4'b0};
                            r_ind     <= r_cfg_seed;
                            r_pct     <= r_prev_pct;
                            r_cur     <= '0;
                            r_state   <= S_DONE;
                        end else begin
                            r_sys_acc <= w_sys_next;
                            r_bat_acc <= w_bat_next;
                            r_neg     <= w_diff[16];
                            r_dq      <= {w_dend, 11'b0};
                            r_rem     <= '0;
                            r_divisor <= K_DIV_15;
                            r_cnt     <= 5'd16;
                            r_state   <= S_DIV_D;
                        end
                    end
                end
                S_DIV_D: begin
                    r_rem <= w_div_rem;
                    if (r_cnt == 5'd1) begin
                        r_dmag   <= w_div_dq[12:0];
                        r_cur    <= w_cur;
                        r_mcand  <= {10'b0, w_cur_mag};
                        r_mplier <= r_cfg_rint;
                        r_dq     <= '0;
                        r_cnt    <= 5'(K_RINT_W);
                        r_state  <= S_MUL;
                    end else begin
                        r_dq  <= w_div_dq;
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_MUL: begin
                    r_dq     <= w_mul_sum;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == 5'd1) begin
                        r_rem     <= '0;
                        r_divisor <= K_DIV_1000;
                        r_cnt     <= 5'd27;
                        r_state   <= S_DIV_DROP;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_DIV_DROP: begin
                    r_dq  <= w_div_dq;
                    r_rem <= w_div_rem;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_ind   <= w_ind_next;
                    r_state <= S_PCT;
                end
                S_PCT: begin
                    if (w_num[18]) begin
                        r_pct   <= '0;
                        r_state <= S_DONE;
                    end else if (w_num >= K_PCT_SAT) begin
                        r_pct   <= 7'd100;
                        r_state <= S_DONE;
                    end else begin
                        r_dq      <= {w_num[10:0], 16'b0};
                        r_rem     <= '0;
                        r_divisor <= K_DIV_15;
                        r_cnt     <= 5'd11;
                        r_state   <= S_DIV_PCT;
                    end
                end
                S_DIV_PCT: begin
                    r_dq  <= w_div_dq;
                    r_rem <= w_div_rem;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_pct   <= w_div_dq[K_PCT_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pct   <= r_pct;
                        r_out_cur   <= r_cur;
                        r_out_ind   <= r_ind;
                        if (r_seed) begin
                            r_out_state <= r_status;
                            r_out_chg   <= 1'b0;
                        end else begin
                            r_out_state <= w_status;
                            r_out_chg   <= w_changed;
                            r_status    <= w_status;
                            r_prev_pct  <= r_pct;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ test/battery_fuel_gauge_estimator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_fuel_gauge_estimator_core_tb: self-checking bench for the fuel gauge
// Drives ADC sample pairs and seed loads through the sample channel with
// random source and sink stalls, predicts every estimate with a local model
// of the filters, indicator and charge state machine, and compares each
// estimate field by field. Runs a short directed table at reset settings,
// then random phases under realistic, extreme and fully random registers.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_estimator_core_tb;
    import bfge_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 70;
    localparam int DIRECTED_ROWS = 16;
    localparam int MAX_REPORTS   = 10;

    localparam logic [K_CFG_IDX_W-1:0] REG_NONE = 3'd7;  // unmapped index

    typedef struct packed {
        logic [K_PCT_W-1:0]   percent;
        t_charge              charge_state;
        logic [K_CUR_W-1:0]   current_ma;
        logic [K_VOLT_W-1:0]  indicator_mv;
        logic                 changed;
    } t_estimate;

    typedef struct packed {
        logic [K_RINT_W-1:0]         rint;
        logic [K_DB_W-1:0]           deadband;
        logic [K_VOLT_W-1:0]         seed_mv;
        logic [K_VOLT_W-1:0]         full_mv;
        logic [K_VOLT_W-1:0]         chgd_mv;
        logic signed [K_LIMIT_W-1:0] dis_lim;
        logic signed [K_LIMIT_W-1:0] chgd_lim;
    } t_gauge_cfg;

    typedef struct packed {
        logic [K_ADC_W-1:0] sys_adc;
        logic [K_ADC_W-1:0] bat_adc;
        logic               seed;
        logic               typed;
        t_estimate          est;
    } t_step_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [K_CFG_IDX_W-1:0] i_cfg_idx;
    logic [K_CFG_DAT_W-1:0] i_cfg_data;

    bfge_in_if  sample_ch ();
    bfge_out_if estimate_ch ();

    battery_fuel_gauge_estimator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch),
        .o_out      (estimate_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state and register copy
    t_gauge_cfg          gauge_cfg;
    logic [K_VOLT_W-1:0] sys_acc;
    logic [K_VOLT_W-1:0] bat_acc;
    logic [K_VOLT_W-1:0] ind_mv;
    t_charge             status;
    logic [K_PCT_W-1:0]  last_pct;

    t_estimate expected_estimates [$];
    logic      drv_typed;
    t_estimate drv_typed_est;

    int mismatches        = 0;
    int estimates_checked = 0;
    int samples_sent      = 0;
    int seeds_sent        = 0;
    int idle_cycles       = 0;
    int state_hits [4]    = '{0, 0, 0, 0};
    bit src_burst         = 1'b0;
    bit snk_burst         = 1'b0;

    function automatic int adc_to_millivolts(input logic [K_ADC_W-1:0] adc);
        int a;
        a = adc;
        return (a * 3000) / 1024;
    endfunction

    function automatic logic [K_ADC_W-1:0] clamp_adc(input int v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Occasionally flips into or out of a no-stall stretch.
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 24) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic t_estimate estimate_next(input logic [K_ADC_W-1:0] sys_raw,
                                                input logic [K_ADC_W-1:0] bat_raw,
                                                input logic sd);
        t_estimate r;
        int        s, b, diff, cur, comp, lvl, db, full, chg, num, pct, rint, dl, cl;
        longint    drop;
        t_charge   prev_state;
        if (sd) begin
            sys_acc = {4'b0, sys_raw, 4'b0};
            bat_acc = sys_acc;
            ind_mv  = gauge_cfg.seed_mv;
            r.percent      = last_pct;
            r.charge_state = status;
            r.current_ma   = '0;
            r.indicator_mv = ind_mv;
            r.changed      = 1'b0;
            return r;
        end
        sys_acc = sys_acc - (sys_acc >> 3) + adc_to_millivolts(sys_raw);
        bat_acc = bat_acc - (bat_acc >> 3) + adc_to_millivolts(bat_raw);
        s = sys_acc;
        b = bat_acc;
        // sense drop, truncating toward zero at each step
        diff = (b - s) / 16;
        diff = diff * 160 / 150;
        cur  = diff * 20;
        rint = gauge_cfg.rint;
        comp = (s - diff) & 32'hFFFF;
        drop = (longint'(cur) * longint'(rint)) / 1000;
        comp = (comp - int'(drop)) & 32'hFFFF;

        lvl = ind_mv;
        db  = gauge_cfg.deadband;
        if (comp > lvl + db) begin
            ind_mv = ind_mv + 16'd1;
        end else if (comp < lvl - db) begin
            ind_mv = ind_mv - 16'd1;
        end
        lvl  = ind_mv;
        full = gauge_cfg.full_mv;
        num  = 1500 - 2 * (full - lvl);
        pct  = num / 15;
        if (pct < 0) begin
            pct = 0;
        end else if (pct > 100) begin
            pct = 100;
        end

        prev_state = status;
        dl  = gauge_cfg.dis_lim;
        cl  = gauge_cfg.chgd_lim;
        chg = gauge_cfg.chgd_mv;
        if (cur < dl) begin
            status = CS_DISCHARGING;
        end
        if (cur >= 0) begin
            status = CS_CHARGING;
        end
        if (lvl > chg && cur > cl) begin
            status = CS_CHARGED;
        end

        r.percent      = pct[6:0];
        r.charge_state = status;
        r.current_ma   = 18'(cur);
        r.indicator_mv = ind_mv;
        r.changed      = (status != prev_state) || (pct[6:0] != last_pct);
        last_pct       = pct[6:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            end
        end
    endtask

    // Leaves the write enable high so back-to-back writes need no lowering.
    task automatic write_reg(input logic [K_CFG_IDX_W-1:0] idx,
                             input logic [K_CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_config(input t_gauge_cfg c);
        write_reg(REG_RINT,     {6'b0, c.rint});
        write_reg(REG_DEADBAND, {8'b0, c.deadband});
        write_reg(REG_SEED_MV,  c.seed_mv);
        write_reg(REG_FULL_MV,  c.full_mv);
        write_reg(REG_CHGD_MV,  c.chgd_mv);
        write_reg(REG_DIS_LIM,  c.dis_lim);
        write_reg(REG_CHGD_LIM, c.chgd_lim);
        write_reg(REG_NONE,     16'($urandom));  // must be ignored
        i_cfg_we  <= 1'b0;
        gauge_cfg  = c;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_sample(input logic [K_ADC_W-1:0] sys_raw,
                               input logic [K_ADC_W-1:0] bat_raw,
                               input logic sd, input logic typed,
                               input t_estimate typed_est);
        int gap;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.sys_adc <= sys_raw;
        sample_ch.bat_adc <= bat_raw;
        sample_ch.seed    <= sd;
        drv_typed         <= typed;
        drv_typed_est     <= typed_est;
        do @(posedge i_clk); while (!sample_ch.ready);
        samples_sent++;
        if (sd) begin
            seeds_sent++;
        end
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : monitor
        t_estimate got, want, next_est;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (estimate_ch.valid && estimate_ch.ready) begin
                moved            = 1'b1;
                got.percent      = estimate_ch.percent;
                got.charge_state = t_charge'(estimate_ch.charge_state);
                got.current_ma   = estimate_ch.current_ma;
                got.indicator_mv = estimate_ch.indicator_mv;
                got.changed      = estimate_ch.changed;
                if (expected_estimates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: estimate with none pending", $time);
                    end
                end else begin
                    want = expected_estimates.pop_front();
                    check_field("percent",      want.percent,      got.percent);
                    check_field("charge_state", want.charge_state, got.charge_state);
                    check_field("current_ma",   want.current_ma,   got.current_ma);
                    check_field("indicator_mv", want.indicator_mv, got.indicator_mv);
                    check_field("changed",      want.changed,      got.changed);
                    estimates_checked++;
                    state_hits[got.charge_state]++;
                end
            end
            if (sample_ch.valid && sample_ch.ready) begin
                moved    = 1'b1;
                next_est = estimate_next(sample_ch.sys_adc, sample_ch.bat_adc,
                                         sample_ch.seed);
                expected_estimates.push_back(drv_typed ? drv_typed_est : next_est);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("no transfer for %0d cycles, %0d estimates pending",
                 STALL_LIMIT, expected_estimates.size());
        $display("battery_fuel_gauge_estimator_core_tb: FAIL");
        $finish;
    end

    initial begin : result_sink
        int gap;
        estimate_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(snk_burst);
            if (gap > 0) begin
                estimate_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            estimate_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!estimate_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_step_row  rows [DIRECTED_ROWS];
        t_gauge_cfg next_cfg;
        t_estimate  no_est;
        int         level, offset, run_len, lim, phase_start;
        logic [7:0] sys_raw;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_RINT;
        i_cfg_data        = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.sys_adc = '0;
        sample_ch.bat_adc = '0;
        sample_ch.seed    = 1'b0;
        drv_typed         = 1'b0;
        drv_typed_est     = '0;
        no_est            = '0;

        gauge_cfg = '{RST_RINT, RST_DEADBAND, RST_SEED_MV, RST_FULL_MV, RST_CHGD_MV,
                      RST_DIS_LIM, RST_CHGD_LIM};
        sys_acc  = '0;
        bat_acc  = '0;
        ind_mv   = '0;
        status   = CS_DISCHARGING;
        last_pct = '0;

        // Only the first two rows follow from reset alone.
        rows = '{
            '{8'd0,   8'd0,   1'b0, 1'b1, '{7'd0, CS_CHARGING, 18'd0, 16'd0,    1'b1}},
            '{8'd255, 8'd0,   1'b1, 1'b1, '{7'd0, CS_CHARGING, 18'd0, 16'd3800, 1'b0}},
            '{8'd255, 8'd255, 1'b0, 1'b0, '0},
            '{8'd255, 8'd0,   1'b0, 1'b0, '0},
            '{8'd0,   8'd255, 1'b0, 1'b0, '0},
            '{8'd0,   8'd0,   1'b0, 1'b0, '0},
            '{8'd170, 8'd85,  1'b0, 1'b0, '0},
            '{8'd85,  8'd170, 1'b0, 1'b0, '0},
            '{8'd0,   8'd255, 1'b1, 1'b0, '0},  // seed ignores bat_adc
            '{8'd128, 8'd128, 1'b0, 1'b0, '0},
            '{8'd200, 8'd190, 1'b0, 1'b0, '0},
            '{8'd200, 8'd210, 1'b0, 1'b0, '0},
            '{8'd1,   8'd254, 1'b0, 1'b0, '0},
            '{8'd254, 8'd1,   1'b0, 1'b0, '0},
            '{8'd0,   8'd0,   1'b1, 1'b0, '0},
            '{8'd255, 8'd255, 1'b0, 1'b0, '0}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            push_sample(rows[k].sys_adc, rows[k].bat_adc, rows[k].seed,
                        rows[k].typed, rows[k].est);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            sample_ch.valid <= 1'b0;
            do @(negedge i_clk); while (expected_estimates.size() != 0);
            repeat (SETTLE_CYCLES) @(negedge i_clk);

            case (phase)
                1: next_cfg = '{10'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000};
                3: next_cfg = '{10'd1023, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
                4: begin
                    next_cfg.rint     = $urandom_range(0, 1023);
                    next_cfg.deadband = $urandom_range(0, 255);
                    next_cfg.seed_mv  = $urandom_range(0, 65535);
                    next_cfg.full_mv  = $urandom_range(0, 65535);
                    next_cfg.chgd_mv  = $urandom_range(0, 65535);
                    lim = $urandom_range(0, 32768);
                    next_cfg.dis_lim  = 16'(-lim);
                    lim = $urandom_range(0, 32768);
                    next_cfg.chgd_lim = 16'(-lim);
                end
                default: begin
                    // voltages near a cell's working range so the indicator tracks
                    next_cfg.rint     = $urandom_range(0, 1023);
                    next_cfg.deadband = $urandom_range(0, 50);
                    next_cfg.seed_mv  = $urandom_range(3000, 4500);
                    next_cfg.full_mv  = next_cfg.seed_mv + $urandom_range(0, 300) - 100;
                    next_cfg.chgd_mv  = next_cfg.seed_mv + $urandom_range(0, 200) - 50;
                    lim = $urandom_range(0, 200);
                    next_cfg.dis_lim  = 16'(-lim);
                    lim = $urandom_range(0, 200);
                    next_cfg.chgd_lim = 16'(-lim);
                end
            endcase
            apply_config(next_cfg);

            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    // seed near the level whose filtered voltage matches the seed
                    level = gauge_cfg.seed_mv;
                    level = level * 1024 / 24000 + $urandom_range(0, 20) - 10;
                    push_sample(clamp_adc(level), 8'($urandom), 1'b1, 1'b0, no_est);
                    offset  = $urandom_range(0, 16) - 8;
                    run_len = $urandom_range(10, 40);
                    repeat (run_len) begin
                        sys_raw = clamp_adc(level + $urandom_range(0, 4) - 2);
                        push_sample(sys_raw,
                                    clamp_adc(sys_raw + offset + $urandom_range(0, 2) - 1),
                                    1'b0, 1'b0, no_est);
                    end
                end else begin
                    push_sample(8'($urandom), 8'($urandom), 1'($urandom), 1'b0, no_est);
                end
            end
        end

        sample_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_estimates.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d samples (%0d seed loads) over %0d register settings, %0d estimates checked",
                 samples_sent, seeds_sent, PHASES + 1, estimates_checked);
        $display("charge states seen: discharging %0d, charging %0d, charged %0d",
                 state_hits[0], state_hits[1], state_hits[2]);
        if (mismatches == 0 && expected_estimates.size() == 0) begin
            $display("battery_fuel_gauge_estimator_core_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d estimates never arrived",
                     mismatches, expected_estimates.size());
            $display("battery_fuel_gauge_estimator_core_tb: FAIL");
        end
        $finish;
    end

endmodule
